// ===== hdl/u8sd_pkg.sv =====
`timescale 1ns / 1ps

package u8sd_pkg;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_OVERLONG = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  localparam int unsigned CP_W = 31;
  localparam int unsigned ST_W = 3;

  // result queue depth, a power of two so the pointers wrap on their own
  localparam int unsigned FIFO_DEPTH = 4;

  // one result transaction
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [ST_W-1:0] st;
    logic            last;
  } res_t;

endpackage

// ===== hdl/utf8_stream_decoder_unit.sv =====
`timescale 1ns / 1ps

// channel | direction | ports
// --------+-----------+-----------------------------------------------------
// input   | in        | in_valid, in_stall, in_byte
// result  | out       | out_valid, out_stall, out_code_point, out_status,
//         |           | out_last_of_run
//
// one byte is taken per cycle while in_stall is low; a byte passes through the
// input register, then the result queue, before its first result shows.
// a byte that gives two results holds the result port for both of them, which
// is what sets the rate when such bytes come in a row.
// rst_n is synchronous, active low, and empties both stages and the decoder
// state. out_stall backs up into the queue; in_stall rises only once the
// queue has fewer than two free entries and the input register is full.

module utf8_stream_decoder_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [u8sd_pkg::CP_W-1:0] out_code_point,
  output logic [u8sd_pkg::ST_W-1:0] out_status,
  output logic                    out_last_of_run
);
  import u8sd_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic        emit;
    res_t        res;
    logic        load;
    logic [2:0]  len;
    logic [4:0]  pay;
  } lead_t;

  // decode of a byte seen while no sequence is open
  function automatic lead_t lead_dec(input logic [7:0] b);
    lead_t d;
    d = '0;
    if (b inside {[8'h00:8'h7F]}) begin
      d.emit   = 1'b1;
      d.res.cp = CP_W'(b);
      d.res.st = ST_OK;
    end else if (b inside {[8'h80:8'hBF], 8'hFE, 8'hFF}) begin
      d.emit   = 1'b1;
      d.res.st = ST_BAD_LEAD;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      d.load = 1'b1;
      d.len  = 3'd2;
      d.pay  = b[4:0];
    end else if (b inside {[8'hE0:8'hEF]}) begin
      d.load = 1'b1;
      d.len  = 3'd3;
      d.pay  = {1'b0, b[3:0]};
    end else if (b inside {[8'hF0:8'hF7]}) begin
      d.load = 1'b1;
      d.len  = 3'd4;
      d.pay  = {2'b0, b[2:0]};
    end else if (b inside {[8'hF8:8'hFB]}) begin
      d.load = 1'b1;
      d.len  = 3'd5;
      d.pay  = {3'b0, b[1:0]};
    end else begin
      d.load = 1'b1;
      d.len  = 3'd6;
      d.pay  = {4'b0, b[0]};
    end
    return d;
  endfunction

  // shortest form length for a value
  function automatic logic [2:0] min_len(input logic [CP_W-1:0] v);
    logic [2:0] l;
    if (v < CP_W'(32'h80))            l = 3'd1;
    else if (v < CP_W'(32'h800))      l = 3'd2;
    else if (v < CP_W'(32'h10000))    l = 3'd3;
    else if (v < CP_W'(32'h200000))   l = 3'd4;
    else if (v < CP_W'(32'h4000000))  l = 3'd5;
    else                              l = 3'd6;
    return l;
  endfunction

  function automatic logic scalar_ok(input logic [CP_W-1:0] v);
    logic ok;
    ok = 1'b1;
    if (v >= CP_W'(32'h110000)) ok = 1'b0;
    if ((v & CP_W'(32'hFFFFF800)) == CP_W'(32'hD800)) ok = 1'b0;
    if (v >= CP_W'(32'hFDD0) && v <= CP_W'(32'hFDEF)) ok = 1'b0;
    if ((v & CP_W'(32'hFFFE)) == CP_W'(32'hFFFE)) ok = 1'b0;
    return ok;
  endfunction

  // input register
  logic        byte_vld_r, byte_vld_nxt;
  logic [7:0]  byte_r;

  // decoder state
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [2:0]      rem_r, rem_nxt;
  logic [2:0]      len_r, len_nxt;

  // result queue
  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic            fire;
  logic            in_acc;
  logic            pop;
  lead_t           ld;
  logic            cont;
  logic [CP_W-1:0] acc_sh;
  logic [2:0]      rem_dec;
  res_t            res0, res1;
  logic [1:0]      push_n;

  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign fire     = byte_vld_r && (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_stall = byte_vld_r && !fire;

  // decode one byte against the open sequence
  always_comb begin
    ld      = lead_dec(byte_r);
    cont    = (byte_r[7:6] == 2'b10);
    acc_sh  = {acc_r[CP_W-7:0], byte_r[5:0]};
    rem_dec = rem_r - 3'd1;
    res0    = '0;
    res1    = '0;
    push_n  = 2'd0;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    len_nxt = len_r;
    if (rem_r == 3'd0) begin
      if (ld.emit) begin
        res0   = ld.res;
        push_n = 2'd1;
      end
      if (ld.load) begin
        acc_nxt = CP_W'(ld.pay);
        len_nxt = ld.len;
        rem_nxt = ld.len - 3'd1;
      end
    end else if (cont) begin
      acc_nxt = acc_sh;
      rem_nxt = rem_dec;
      if (rem_dec == 3'd0) begin
        push_n = 2'd1;
        if (min_len(acc_sh) != len_r) begin
          res0.st = ST_OVERLONG;
        end else if (!scalar_ok(acc_sh)) begin
          res0.st = ST_INVALID;
        end else begin
          res0.st = ST_OK;
          res0.cp = acc_sh;
        end
        acc_nxt = '0;
        len_nxt = 3'd0;
      end
    end else begin
      // truncated sequence, then the same byte starts over as a lead
      res0.st = ST_TRUNC;
      push_n  = 2'd1;
      acc_nxt = '0;
      rem_nxt = 3'd0;
      len_nxt = 3'd0;
      if (ld.emit) begin
        res1   = ld.res;
        push_n = 2'd2;
      end
      if (ld.load) begin
        acc_nxt = CP_W'(ld.pay);
        len_nxt = ld.len;
        rem_nxt = ld.len - 3'd1;
      end
    end
    res0.last = (push_n == 2'd1);
    res1.last = 1'b1;
  end

  // input register valid, queue pointer and count update
  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_acc) begin
      byte_vld_nxt = 1'b1;
    end else if (fire) begin
      byte_vld_nxt = 1'b0;
    end
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (fire) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
      cnt_nxt    = cnt_r + CNT_W'(push_n);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
      cnt_nxt    = cnt_nxt - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
      acc_r      <= '0;
      rem_r      <= 3'd0;
      len_r      <= 3'd0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
      if (fire) begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
        len_r <= len_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_byte;
    end
    if (fire && push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (fire && push_n == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // result port
  assign out_valid       = (cnt_r != '0);
  assign out_code_point  = fifo_r[rd_ptr_r].cp;
  assign out_status      = fifo_r[rd_ptr_r].st;
  assign out_last_of_run = fifo_r[rd_ptr_r].last;

endmodule

// ===== hdl/u8sd_checker.sv =====
`timescale 1ns / 1ps

module u8sd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [u8sd_pkg::CP_W-1:0] out_code_point,
  input logic [u8sd_pkg::ST_W-1:0] out_status,
  input logic                      out_last_of_run
);
  import u8sd_pkg::*;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point)
      && $stable(out_status) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // errors carry no code point
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_code_point == '0)
    else $error("error result with nonzero code point");

  // a good character lies within the scalar range
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_code_point < 31'h110000)
    else $error("ok result out of scalar range");

  // only a truncation can be followed by a second result of the same byte
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TRUNC |-> out_last_of_run)
    else $error("non-truncation result not marked last");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_u8sd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_point  (out_code_point),
  .out_status      (out_status),
  .out_last_of_run (out_last_of_run)
);

// ===== tb/sv/utf8_stream_decoder_checker.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              in_byte,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [u8sd_pkg::CP_W-1:0] out_code_point,
  input  logic [u8sd_pkg::ST_W-1:0] out_status,
  input  logic                    out_last_of_run,
  output int                      fail_count,
  output int                      pending,
  output int                      chars_ok,
  output int                      chars_err,
  output int                      two_result_bytes
);

  import u8sd_pkg::*;

  // decoded characters and errors still waiting to appear on the result port
  res_t            char_q[$];

  // shadow decoder state
  logic [CP_W-1:0] acc;
  logic [2:0]      bytes_left;
  logic [2:0]      form_len;

  // shortest utf-8 form that can carry this value
  function automatic logic [2:0] shortest_form(input logic [CP_W-1:0] v);
    if (v < 31'h80) return 3'd1;
    if (v < 31'h800) return 3'd2;
    if (v < 31'h10000) return 3'd3;
    if (v < 31'h200000) return 3'd4;
    if (v < 31'h4000000) return 3'd5;
    return 3'd6;
  endfunction

  // unicode scalar rules: range, surrogates, noncharacters
  function automatic logic legal_scalar(input logic [CP_W-1:0] v);
    logic [31:0] w;
    w = {1'b0, v};
    if (w >= 32'h110000) return 1'b0;
    if ((w & 32'hFFFFF800) == 32'hD800) return 1'b0;
    if (w >= 32'hFDD0 && w <= 32'hFDEF) return 1'b0;
    if ((w & 32'hFFFE) == 32'hFFFE) return 1'b0;
    return 1'b1;
  endfunction

  function automatic res_t mk_result(input logic [CP_W-1:0] cp, input logic [ST_W-1:0] st);
    res_t r;
    r.cp   = cp;
    r.st   = st;
    r.last = 1'b0;
    return r;
  endfunction

  // advance the shadow decoder by one byte and queue what it produces
  task automatic decode_byte(input logic [7:0] b);
    res_t            outs [2];
    int              n_out;
    logic [CP_W-1:0] v;
    n_out = 0;
    // a non-continuation byte cuts the open sequence short
    if (bytes_left != 3'd0 && b[7:6] != 2'b10) begin
      outs[n_out] = mk_result('0, ST_TRUNC);
      n_out++;
      acc        = '0;
      bytes_left = 3'd0;
      form_len   = 3'd0;
    end
    if (bytes_left == 3'd0) begin
      // idle: ascii, bad lead or start of a multi-byte form
      if (b < 8'h80) begin
        outs[n_out] = mk_result(CP_W'(b), ST_OK);
        n_out++;
      end else if (b < 8'hC0 || b >= 8'hFE) begin
        outs[n_out] = mk_result('0, ST_BAD_LEAD);
        n_out++;
      end else begin
        if (b < 8'hE0) begin
          form_len = 3'd2;
          acc      = CP_W'(b[4:0]);
        end else if (b < 8'hF0) begin
          form_len = 3'd3;
          acc      = CP_W'(b[3:0]);
        end else if (b < 8'hF8) begin
          form_len = 3'd4;
          acc      = CP_W'(b[2:0]);
        end else if (b < 8'hFC) begin
          form_len = 3'd5;
          acc      = CP_W'(b[1:0]);
        end else begin
          form_len = 3'd6;
          acc      = CP_W'(b[0]);
        end
        bytes_left = form_len - 3'd1;
      end
    end else begin
      // continuation: shift in six payload bits
      acc        = {acc[CP_W-7:0], b[5:0]};
      bytes_left = bytes_left - 3'd1;
      if (bytes_left == 3'd0) begin
        v = acc;
        if (shortest_form(v) != form_len) outs[n_out] = mk_result('0, ST_OVERLONG);
        else if (!legal_scalar(v)) outs[n_out] = mk_result('0, ST_INVALID);
        else outs[n_out] = mk_result(v, ST_OK);
        n_out++;
        acc      = '0;
        form_len = 3'd0;
      end
    end
    if (n_out > 0) outs[n_out-1].last = 1'b1;
    if (n_out == 2) two_result_bytes++;
    for (int i = 0; i < n_out; i++) char_q.push_back(outs[i]);
  endtask

  // watch both channels, predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      acc              = '0;
      bytes_left       = 3'd0;
      form_len         = 3'd0;
      fail_count       = 0;
      chars_ok         = 0;
      chars_err        = 0;
      two_result_bytes = 0;
      char_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          $error("unexpected result: code_point %h status %0d last_of_run %b",
                 out_code_point, out_status, out_last_of_run);
          fail_count++;
        end else begin
          want = char_q.pop_front();
          if (want.st == ST_OK) chars_ok++;
          else chars_err++;
          if (want.cp !== out_code_point) begin
            $error("code_point: expected %h, actual %h", want.cp, out_code_point);
            fail_count++;
          end
          if (want.st !== out_status) begin
            $error("status: expected %0d, actual %0d", want.st, out_status);
            fail_count++;
          end
          if (want.last !== out_last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last, out_last_of_run);
            fail_count++;
          end
        end
      end
    end
    pending <= char_q.size();
  end

endmodule

// ===== tb/sv/utf8_stream_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;

  import u8sd_pkg::*;

  localparam int RANDOM_BYTES = 1250;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;
  // long receiver hold-off and stretches without idling
  localparam int HOLD_START   = 300;
  localparam int HOLD_LEN     = 80;
  localparam int RX_BUSY_LO   = 1500;
  localparam int RX_BUSY_HI   = 2200;
  localparam int TX_BUSY_LO   = 600;
  localparam int TX_BUSY_HI   = 900;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [7:0]      in_byte;
  logic            out_valid;
  logic            out_stall;
  logic [CP_W-1:0] out_code_point;
  logic [ST_W-1:0] out_status;
  logic            out_last_of_run;

  int              fail_count;
  int              pending;
  int              chars_ok;
  int              chars_err;
  int              two_result_bytes;
  int              quiet_cycles;
  int              rx_cycle;
  logic [7:0]      byte_stream[$];

  utf8_stream_decoder_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  utf8_stream_decoder_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending         (pending),
    .chars_ok        (chars_ok),
    .chars_err       (chars_err),
    .two_result_bytes(two_result_bytes)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // largest value each form length can carry
  function automatic logic [30:0] form_max(input int len);
    case (len)
      1: return 31'h7F;
      2: return 31'h7FF;
      3: return 31'hFFFF;
      4: return 31'h1FFFFF;
      5: return 31'h3FFFFFF;
      default: return 31'h7FFFFFFF;
    endcase
  endfunction

  // append one character encoded in len bytes, keeping only the first keep bytes
  task automatic push_encoded(input logic [30:0] cp, input int len, input int keep);
    logic [7:0] lead_prefix;
    case (len)
      2: lead_prefix = 8'hC0;
      3: lead_prefix = 8'hE0;
      4: lead_prefix = 8'hF0;
      5: lead_prefix = 8'hF8;
      default: lead_prefix = 8'hFC;
    endcase
    if (len == 1) begin
      byte_stream.push_back({1'b0, cp[6:0]});
    end else begin
      byte_stream.push_back(lead_prefix | 8'(cp >> (6 * (len - 1))));
      for (int k = len - 2; k >= len - keep - 1 + 0 && k >= 0; k--) begin
        if (len - 1 - k < keep) byte_stream.push_back(8'h80 | 8'((cp >> (6 * k)) & 31'h3F));
      end
    end
  endtask

  // one random stimulus unit: mostly well-formed characters, some cut short, some noise
  task automatic add_random_unit();
    logic [30:0] cp;
    int          len;
    int          keep;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      byte_stream.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 11))
      0, 1: begin
        len = 1;
        cp  = 31'($urandom_range(0, 'h7F));
      end
      2, 3: begin
        len = 2;
        cp  = 31'($urandom_range('h80, 'h7FF));
      end
      4, 5: begin
        len = 3;
        cp  = 31'($urandom_range('h800, 'hFFFF));
      end
      6: begin
        // surrogates, the noncharacter block and the ffff/fffe tail in the bmp
        len = 3;
        case ($urandom_range(0, 2))
          0: cp = 31'('hD800 + $urandom_range(0, 'h7FF));
          1: cp = 31'('hFDCF + $urandom_range(0, 'h21));
          default: cp = 31'('hFFFE + $urandom_range(0, 1));
        endcase
      end
      7, 8: begin
        len = 4;
        cp  = 31'($urandom_range('h10000, 'h10FFFF));
        if ($urandom_range(0, 3) == 0) cp[15:0] = {15'h7FFF, 1'($urandom)};
      end
      9: begin
        len = 4;
        cp  = 31'($urandom_range('h10F000, 'h1FFFFF));
      end
      10: begin
        len = $urandom_range(5, 6);
        cp  = 31'($urandom_range(form_max(len - 1) + 1, form_max(len)));
      end
      default: begin
        // overlong: a value that fits a shorter form
        len = $urandom_range(2, 6);
        cp  = 31'($urandom_range(0, form_max(len - 1)));
      end
    endcase
    keep = len;
    if (kind < 25 && len > 1) keep = $urandom_range(1, len - 1);
    push_encoded(cp, len, keep);
  endtask

  // offer one byte and hold it until the decoder takes it
  task automatic send_byte(input logic [7:0] b, input logic may_idle);
    while (may_idle && $urandom_range(0, 99) < 37) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    out_stall <= 1'b0;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) out_stall <= 1'b1;
      else if (rx_cycle >= RX_BUSY_LO && rx_cycle < RX_BUSY_HI) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 37);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL utf8_stream_decoder_unit");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int n_directed;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;

    // extremes, stray continuation, bad leads
    byte_stream = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFE};
    // two-byte ok, overlong two-byte
    byte_stream.push_back(8'hC2); byte_stream.push_back(8'hA9);
    byte_stream.push_back(8'hC1); byte_stream.push_back(8'hBF);
    // surrogate and noncharacter block
    byte_stream.push_back(8'hED); byte_stream.push_back(8'hA0); byte_stream.push_back(8'h80);
    byte_stream.push_back(8'hEF); byte_stream.push_back(8'hB7); byte_stream.push_back(8'h90);
    // five-byte form, never a valid scalar
    byte_stream.push_back(8'hF8); byte_stream.push_back(8'h88); byte_stream.push_back(8'h80);
    byte_stream.push_back(8'h80); byte_stream.push_back(8'h80);
    // truncation followed by ascii, then by a bad lead
    byte_stream.push_back(8'hE2); byte_stream.push_back(8'h41);
    byte_stream.push_back(8'hF0); byte_stream.push_back(8'hFE);
    n_directed = byte_stream.size();

    while (byte_stream.size() < n_directed + RANDOM_BYTES) add_random_unit();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (byte_stream[i])
      send_byte(byte_stream[i], !(i >= TX_BUSY_LO && i < TX_BUSY_HI));
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input bytes: %0d characters decoded ok, %0d error results",
             byte_stream.size(), chars_ok, chars_err);
    $display("%0d bytes closed a truncated sequence and gave a second result",
             two_result_bytes);
    if (fail_count == 0) begin
      $display("PASS utf8_stream_decoder_unit");
    end else begin
      $display("FAIL utf8_stream_decoder_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/u8sd_pkg.sv
hdl/utf8_stream_decoder_unit.sv
hdl/u8sd_checker.sv
tb/sv/utf8_stream_decoder_checker.sv
tb/sv/utf8_stream_decoder_unit_tb.sv
